// ----- sv/tlq_pkg.sv -----
// Package: payload types, widths and helpers of the thick line quad expansion block.
package tlq_pkg;

	localparam int CW            = 32;  // coordinate width, signed Q16.16 words
	localparam int FRAC_BITS_DEF = 16;  // default fraction bits
	localparam int NORM_W        = 30;  // normalized magnitude width, msb lands on bit 29
	localparam int NORM_MSB      = NORM_W - 1;
	localparam int MAG_W         = CW + 1;            // |end - start| width
	localparam int POS_W         = $clog2(MAG_W);     // leading-one position width
	localparam int SQR_W         = 2 * NORM_W;        // one square
	localparam int SUM_W         = 2 * NORM_W + 2;    // padded sum of squares, even width
	localparam int ROOT_W        = SUM_W / 2;         // square root width
	localparam int REM_W         = ROOT_W + 3;        // root remainder plus two new bits

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic        [CW-2:0] line_thickness;
	} seg_t;

	typedef struct packed {
		logic signed [CW-1:0] corner0_x;
		logic signed [CW-1:0] corner0_y;
		logic signed [CW-1:0] corner1_x;
		logic signed [CW-1:0] corner1_y;
		logic signed [CW-1:0] corner2_x;
		logic signed [CW-1:0] corner2_y;
		logic signed [CW-1:0] corner3_x;
		logic signed [CW-1:0] corner3_y;
		logic                 degenerate;
	} quad_t;

	// Side data that rides along the whole pipe.
	typedef struct packed {
		seg_t seg;
		logic degen;
		logic dx_pos;
		logic dy_neg;
	} side_t;

	// Clamp a sum to the coordinate range.
	function automatic logic signed [CW-1:0] sat(input logic signed [CW:0] v);
		logic signed [CW:0] hi;
		logic signed [CW:0] lo;
		hi = (CW+1)'(signed'({1'b0, {(CW-1){1'b1}}}));
		lo = -hi - (CW+1)'(1);
		if (v > hi)
			return hi[CW-1:0];
		else if (v < lo)
			return lo[CW-1:0];
		else
			return v[CW-1:0];
	endfunction

endpackage

// ----- sv/thick_line_quad_expansion.sv -----
// Top level: fully pipelined thick line quad expansion, one line segment per clock.
//
// The block expands a line segment plus a thickness into the four corners of its quad.
// A word is taken at every clock edge where start is high; busy is always low, as every
// stage advances on every clock and the receiver cannot stall. The result word appears
// on quad for exactly one cycle with done high, once the word has passed every stage.
// FRAC_BITS defaults to 16. Most stages sit in the square root of the squared length,
// which resolves one root bit per stage (31 stages), and in the two restoring dividers
// that form the unit direction, one quotient bit per stage (FRAC_BITS + 1 stages).
// Corners come out as start + n, end + n, end - n, start - n, each saturated; when
// start equals end the normal is zero and degenerate is set.
module thick_line_quad_expansion #(
	parameter int FRAC_BITS = tlq_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tlq_pkg::seg_t seg,
	output logic          done,
	output tlq_pkg::quad_t quad
);

	localparam int CW       = tlq_pkg::CW;
	localparam int MAG_W    = tlq_pkg::MAG_W;
	localparam int POS_W    = tlq_pkg::POS_W;
	localparam int NORM_W   = tlq_pkg::NORM_W;
	localparam int SQR_W    = tlq_pkg::SQR_W;
	localparam int SUM_W    = tlq_pkg::SUM_W;
	localparam int ROOT_W   = tlq_pkg::ROOT_W;
	localparam int REM_W    = tlq_pkg::REM_W;
	localparam int DIV_N    = FRAC_BITS + 1;      // quotient bits per divider
	localparam int DREM_W   = ROOT_W + 1;         // divider remainder after doubling
	localparam int U_W      = FRAC_BITS + 1;      // unit magnitude, at most 2^FRAC_BITS
	localparam int PROD_W   = U_W + CW - 1;

	// No back pressure anywhere.
	assign busy = 1'b0;

	// ---------------------------------------------------------------- s1: deltas
	logic                v_s1;
	tlq_pkg::side_t      sd_s1;
	logic [MAG_W-1:0]    a_s1, b_s1;
	logic signed [CW:0]  dx_c, dy_c;

	assign dx_c = (CW+1)'(seg.end_x) - (CW+1)'(seg.start_x);
	assign dy_c = (CW+1)'(seg.end_y) - (CW+1)'(seg.start_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		sd_s1.seg    <= seg;
		sd_s1.degen  <= (dx_c == '0) && (dy_c == '0);
		sd_s1.dx_pos <= !dx_c[CW] && (dx_c != '0);
		sd_s1.dy_neg <= dy_c[CW];
		a_s1         <= dx_c[CW] ? MAG_W'(-dx_c) : MAG_W'(dx_c);
		b_s1         <= dy_c[CW] ? MAG_W'(-dy_c) : MAG_W'(dy_c);
	end

	// ---------------------------------------------------------------- s2: leading one
	logic                v_s2;
	tlq_pkg::side_t      sd_s2;
	logic [MAG_W-1:0]    a_s2, b_s2;
	logic [POS_W-1:0]    p_s2;
	logic [POS_W-1:0]    p_c;
	logic [MAG_W-1:0]    or_c;

	assign or_c = a_s1 | b_s1;

	always_comb begin
		p_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (or_c[i])
				p_c = POS_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		sd_s2 <= sd_s1;
		a_s2  <= a_s1;
		b_s2  <= b_s1;
		p_s2  <= p_c;
	end

	// ---------------------------------------------------------------- s3: normalize
	// Move the larger magnitude's msb to bit NORM_W-1; right shifts truncate.
	logic                v_s3;
	tlq_pkg::side_t      sd_s3;
	logic [NORM_W-1:0]   na_s3, nb_s3;
	logic [NORM_W-1:0]   na_c, nb_c;

	always_comb begin
		if (p_s2 > POS_W'(tlq_pkg::NORM_MSB)) begin
			na_c = NORM_W'(a_s2 >> (p_s2 - POS_W'(tlq_pkg::NORM_MSB)));
			nb_c = NORM_W'(b_s2 >> (p_s2 - POS_W'(tlq_pkg::NORM_MSB)));
		end else begin
			na_c = NORM_W'(a_s2 << (POS_W'(tlq_pkg::NORM_MSB) - p_s2));
			nb_c = NORM_W'(b_s2 << (POS_W'(tlq_pkg::NORM_MSB) - p_s2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		sd_s3 <= sd_s2;
		na_s3 <= na_c;
		nb_s3 <= nb_c;
	end

	// ---------------------------------------------------------------- s4: squares
	logic                v_s4;
	tlq_pkg::side_t      sd_s4;
	logic [NORM_W-1:0]   na_s4, nb_s4;
	logic [SQR_W-1:0]    asq_s4, bsq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		sd_s4  <= sd_s3;
		na_s4  <= na_s3;
		nb_s4  <= nb_s3;
		asq_s4 <= SQR_W'(na_s3) * SQR_W'(na_s3);
		bsq_s4 <= SQR_W'(nb_s3) * SQR_W'(nb_s3);
	end

	// ---------------------------------------------------------------- s5: sum of squares
	logic                v_s5;
	tlq_pkg::side_t      sd_s5;
	logic [NORM_W-1:0]   na_s5, nb_s5;
	logic [SUM_W-1:0]    sum_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		sd_s5  <= sd_s4;
		na_s5  <= na_s4;
		nb_s5  <= nb_s4;
		sum_s5 <= SUM_W'(asq_s4) + SUM_W'(bsq_s4);
	end

	// ---------------------------------------------------------------- square root
	// Digit by digit: each stage brings down two bits of the sum and settles one root bit.
	logic                v_sq    [0:ROOT_W];
	tlq_pkg::side_t      sd_sq   [0:ROOT_W];
	logic [NORM_W-1:0]   na_sq   [0:ROOT_W];
	logic [NORM_W-1:0]   nb_sq   [0:ROOT_W];
	logic [SUM_W-1:0]    val_sq  [0:ROOT_W];
	logic [REM_W-1:0]    rem_sq  [0:ROOT_W];
	logic [ROOT_W-1:0]   root_sq [0:ROOT_W];

	assign v_sq[0]    = v_s5;
	assign sd_sq[0]   = sd_s5;
	assign na_sq[0]   = na_s5;
	assign nb_sq[0]   = nb_s5;
	assign val_sq[0]  = sum_s5;
	assign rem_sq[0]  = '0;
	assign root_sq[0] = '0;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [REM_W-1:0] r_c;
		logic [REM_W-1:0] trial_c;

		assign r_c     = {rem_sq[k][REM_W-3:0], val_sq[k][SUM_W-1 - 2*k -: 2]};
		assign trial_c = {root_sq[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sq[k+1] <= 1'b0;
			else
				v_sq[k+1] <= v_sq[k];
		end

		always_ff @(posedge clk) begin
			sd_sq[k+1]  <= sd_sq[k];
			na_sq[k+1]  <= na_sq[k];
			nb_sq[k+1]  <= nb_sq[k];
			val_sq[k+1] <= val_sq[k];
			if (r_c >= trial_c) begin
				rem_sq[k+1]  <= r_c - trial_c;
				root_sq[k+1] <= {root_sq[k][ROOT_W-2:0], 1'b1};
			end else begin
				rem_sq[k+1]  <= r_c;
				root_sq[k+1] <= {root_sq[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	// ---------------------------------------------------------------- unit direction
	// Two restoring dividers in step: ua = (a << FRAC_BITS) / len, ub likewise.
	logic                v_dv   [0:DIV_N];
	tlq_pkg::side_t      sd_dv  [0:DIV_N];
	logic [ROOT_W-1:0]   len_dv [0:DIV_N];
	logic [DREM_W-1:0]   ra_dv  [0:DIV_N];
	logic [DREM_W-1:0]   rb_dv  [0:DIV_N];
	logic [U_W-1:0]      qa_dv  [0:DIV_N];
	logic [U_W-1:0]      qb_dv  [0:DIV_N];

	assign v_dv[0]   = v_sq[ROOT_W];
	assign sd_dv[0]  = sd_sq[ROOT_W];
	assign len_dv[0] = root_sq[ROOT_W];
	assign ra_dv[0]  = DREM_W'(na_sq[ROOT_W]);
	assign rb_dv[0]  = DREM_W'(nb_sq[ROOT_W]);
	assign qa_dv[0]  = '0;
	assign qb_dv[0]  = '0;

	for (genvar j = 0; j < DIV_N; j++) begin : g_div
		logic [DREM_W-1:0] ta_c, tb_c;
		logic [DREM_W-1:0] ln_c;

		// The first step compares the remainder as it stands, later steps double it.
		if (j == 0) begin : g_first
			assign ta_c = ra_dv[j];
			assign tb_c = rb_dv[j];
		end else begin : g_next
			assign ta_c = {ra_dv[j][DREM_W-2:0], 1'b0};
			assign tb_c = {rb_dv[j][DREM_W-2:0], 1'b0};
		end
		assign ln_c = DREM_W'(len_dv[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_dv[j+1] <= 1'b0;
			else
				v_dv[j+1] <= v_dv[j];
		end

		always_ff @(posedge clk) begin
			sd_dv[j+1]  <= sd_dv[j];
			len_dv[j+1] <= len_dv[j];
			if (ta_c >= ln_c) begin
				ra_dv[j+1] <= ta_c - ln_c;
				qa_dv[j+1] <= {qa_dv[j][U_W-2:0], 1'b1};
			end else begin
				ra_dv[j+1] <= ta_c;
				qa_dv[j+1] <= {qa_dv[j][U_W-2:0], 1'b0};
			end
			if (tb_c >= ln_c) begin
				rb_dv[j+1] <= tb_c - ln_c;
				qb_dv[j+1] <= {qb_dv[j][U_W-2:0], 1'b1};
			end else begin
				rb_dv[j+1] <= tb_c;
				qb_dv[j+1] <= {qb_dv[j][U_W-2:0], 1'b0};
			end
		end
	end

	// ---------------------------------------------------------------- half offsets
	// ox = floor(ub * t / 2^(FRAC_BITS+1)), oy from ua; both are at most t / 2.
	logic                v_m;
	tlq_pkg::side_t      sd_m;
	logic [CW-2:0]       ox_m, oy_m;
	logic [PROD_W-1:0]   px_c, py_c;

	assign px_c = PROD_W'(qb_dv[DIV_N]) * PROD_W'(sd_dv[DIV_N].seg.line_thickness);
	assign py_c = PROD_W'(qa_dv[DIV_N]) * PROD_W'(sd_dv[DIV_N].seg.line_thickness);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_m <= 1'b0;
		else
			v_m <= v_dv[DIV_N];
	end

	always_ff @(posedge clk) begin
		sd_m <= sd_dv[DIV_N];
		ox_m <= (CW-1)'(px_c >> (FRAC_BITS + 1));
		oy_m <= (CW-1)'(py_c >> (FRAC_BITS + 1));
	end

	// ---------------------------------------------------------------- signed normal
	// Clockwise normal: x follows the sign of dy, y the opposite of dx. Zero it on a point.
	logic                 v_n;
	tlq_pkg::side_t       sd_n;
	logic signed [CW-1:0] nx_n, ny_n;
	logic signed [CW-1:0] oxs_c, oys_c;

	assign oxs_c = signed'(CW'(ox_m));
	assign oys_c = signed'(CW'(oy_m));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_n <= 1'b0;
		else
			v_n <= v_m;
	end

	always_ff @(posedge clk) begin
		sd_n <= sd_m;
		if (sd_m.degen) begin
			nx_n <= '0;
			ny_n <= '0;
		end else begin
			nx_n <= sd_m.dy_neg ? -oxs_c : oxs_c;
			ny_n <= sd_m.dx_pos ? -oys_c : oys_c;
		end
	end

	// ---------------------------------------------------------------- corners
	tlq_pkg::quad_t       quad_q;
	logic                 done_q;
	logic signed [CW:0]   sx_c, sy_c, ex_c, ey_c, nx_c, ny_c;

	assign sx_c = (CW+1)'(sd_n.seg.start_x);
	assign sy_c = (CW+1)'(sd_n.seg.start_y);
	assign ex_c = (CW+1)'(sd_n.seg.end_x);
	assign ey_c = (CW+1)'(sd_n.seg.end_y);
	assign nx_c = (CW+1)'(nx_n);
	assign ny_c = (CW+1)'(ny_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= v_n;
	end

	always_ff @(posedge clk) begin
		quad_q.corner0_x  <= tlq_pkg::sat(sx_c + nx_c);
		quad_q.corner0_y  <= tlq_pkg::sat(sy_c + ny_c);
		quad_q.corner1_x  <= tlq_pkg::sat(ex_c + nx_c);
		quad_q.corner1_y  <= tlq_pkg::sat(ey_c + ny_c);
		quad_q.corner2_x  <= tlq_pkg::sat(ex_c - nx_c);
		quad_q.corner2_y  <= tlq_pkg::sat(ey_c - ny_c);
		quad_q.corner3_x  <= tlq_pkg::sat(sx_c - nx_c);
		quad_q.corner3_y  <= tlq_pkg::sat(sy_c - ny_c);
		quad_q.degenerate <= sd_n.degen;
	end

	assign done = done_q;
	assign quad = quad_q;

	// ---------------------------------------------------------------- checks
	// A normalized nonzero delta gives a length of at least 2^(NORM_W-1).
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_dv[0] && !sd_dv[0].degen |-> len_dv[0][ROOT_W-1:NORM_W-1] != '0)
		else $error("root below normalized range");

	// Unit magnitudes never exceed one.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_dv[DIV_N] && !sd_dv[DIV_N].degen |->
		qa_dv[DIV_N] <= U_W'(1) << FRAC_BITS && qb_dv[DIV_N] <= U_W'(1) << FRAC_BITS)
		else $error("unit direction above one");

	// A point gives corners that sit on the end points.
	a_degen_corners: assert property (@(posedge clk) disable iff (!arst_n)
		done && quad.degenerate |->
		quad.corner0_x == quad.corner3_x && quad.corner0_y == quad.corner3_y &&
		quad.corner1_x == quad.corner2_x && quad.corner1_y == quad.corner2_y)
		else $error("degenerate corners differ");

	// A word in the half offset stage comes out with done, past the signed normal and corner registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_m |=> ##1 done)
		else $error("word lost in the last stages");

endmodule

// ----- dv/thick_line_quad_expansion_test.sv -----
// Testbench: thick line quad expansion checked against a behavioral corner predictor.
module thick_line_quad_expansion_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 39 + tlq_pkg::FRAC_BITS_DEF;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	tlq_pkg::seg_t   seg = '0;
	logic            done;
	tlq_pkg::quad_t  quad;

	thick_line_quad_expansion u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.seg(seg), .done(done), .quad(quad)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	tlq_pkg::seg_t  seg_queue[$];      // segments waiting to be driven
	tlq_pkg::quad_t quad_expect[$];    // corner sets waiting on the output
	int    mismatch_count = 0;
	bit    drain_req = 1'b0;  // initial block asks the driver to hold until empty
	bit    all_queued = 1'b0; // every segment has been put in the queue
	int    gap_left = 0;
	bit    stim_done = 1'b0;

	// Clamp a wide signed value to the coordinate range.
	function automatic logic signed [tlq_pkg::CW-1:0] clamp_coord(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[tlq_pkg::CW-1:0];
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Half-thickness offset: floor(u * t / 2^(FRAC+1)).
	function automatic longint unsigned half_offset(input longint unsigned u,
			input longint unsigned t);
		longint unsigned hi;
		longint unsigned lo;
		hi = u * (t >> tlq_pkg::FRAC_BITS_DEF);
		lo = (u * (t & ((64'd1 << tlq_pkg::FRAC_BITS_DEF) - 1))) >> tlq_pkg::FRAC_BITS_DEF;
		return (hi + lo) >> 1;
	endfunction

	function automatic tlq_pkg::quad_t expand_quad(input tlq_pkg::seg_t s);
		tlq_pkg::quad_t q;
		longint sx, sy, ex, ey, dx, dy, nx, ny;
		longint unsigned a, b, m, len, ua, ub, t;
		sx = longint'(s.start_x);
		sy = longint'(s.start_y);
		ex = longint'(s.end_x);
		ey = longint'(s.end_y);
		t = longint'({1'b0, s.line_thickness});
		dx = ex - sx;
		dy = ey - sy;
		nx = 0;
		ny = 0;
		if (dx != 0 || dy != 0) begin
			a = dx < 0 ? -dx : dx;
			b = dy < 0 ? -dy : dy;
			m = a > b ? a : b;
			while (m >= (64'd1 << 30)) begin
				a >>= 1; b >>= 1; m >>= 1;
			end
			while (m < (64'd1 << 29)) begin
				a <<= 1; b <<= 1; m <<= 1;
			end
			len = root_floor(a * a + b * b);
			ua = (a << tlq_pkg::FRAC_BITS_DEF) / len;
			ub = (b << tlq_pkg::FRAC_BITS_DEF) / len;
			nx = longint'(half_offset(ub, t));
			ny = longint'(half_offset(ua, t));
			if (dy < 0)
				nx = -nx;
			if (dx > 0)
				ny = -ny;
		end
		q.corner0_x = clamp_coord(sx + nx);
		q.corner0_y = clamp_coord(sy + ny);
		q.corner1_x = clamp_coord(ex + nx);
		q.corner1_y = clamp_coord(ey + ny);
		q.corner2_x = clamp_coord(ex - nx);
		q.corner2_y = clamp_coord(ey - ny);
		q.corner3_x = clamp_coord(sx - nx);
		q.corner3_y = clamp_coord(sy - ny);
		q.degenerate = (dx == 0 && dy == 0);
		return q;
	endfunction

	function automatic tlq_pkg::seg_t make_seg(input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] ex, input logic [31:0] ey, input logic [30:0] t);
		tlq_pkg::seg_t s;
		s.start_x = sx;
		s.start_y = sy;
		s.end_x = ex;
		s.end_y = ey;
		s.line_thickness = t;
		return s;
	endfunction

	// Random coordinate: mix of full range, small values and near-extreme values.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			3: return 32'h7fffffff - $urandom_range(0, 1 << 20);
			4: return 32'h80000000 + $urandom_range(0, 1 << 20);
			default: return 32'($signed($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	// Driver: advance one word per accepted edge, insert random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				quad_expect.push_back(expand_quad(seg));
			end
			if (start && busy) begin
				// hold the current word
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (drain_req && (quad_expect.size() != 0 || (start && !busy))) begin
				start <= 1'b0;
			end else if (seg_queue.size() != 0) begin
				seg <= seg_queue.pop_front();
				start <= 1'b1;
				case ($urandom_range(0, 19))
					0: gap_left <= $urandom_range(10, 80);
					1, 2, 3, 4: gap_left <= $urandom_range(1, 3);
					default: gap_left <= 0;
				endcase
			end else begin
				start <= 1'b0;
				if (all_queued && quad_expect.size() == 0 && !(start && !busy))
					stim_done <= 1'b1;
			end
		end
	end

	// Monitor: compare each strobed corner set with the oldest expectation.
	always @(posedge clk) begin
		tlq_pkg::quad_t want;
		if (arst_n && done) begin
			if (quad_expect.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: %p", quad);
			end else begin
				want = quad_expect.pop_front();
				if (quad !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p, actual %p", want, quad);
				end
			end
		end
	end

	initial begin
		logic [31:0] x, y;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, degenerate lines, axis lines, saturation.
		seg_queue.push_back(make_seg(0, 0, 0, 0, 31'h7fffffff));
		seg_queue.push_back(make_seg(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 31'h00010000));
		seg_queue.push_back(make_seg(0, 0, 32'h000a0000, 0, 31'h00020000));
		seg_queue.push_back(make_seg(0, 0, 32'hfff60000, 0, 31'h00020000));
		seg_queue.push_back(make_seg(0, 0, 0, 32'h000a0000, 31'h00020000));
		seg_queue.push_back(make_seg(0, 0, 0, 32'hfff60000, 31'h00020000));
		seg_queue.push_back(make_seg(32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 31'h7fffffff));
		seg_queue.push_back(make_seg(32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 31'h7fffffff));
		seg_queue.push_back(make_seg(32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 31'h55555555));
		seg_queue.push_back(make_seg(0, 0, 1, 0, 31'h7fffffff));
		seg_queue.push_back(make_seg(0, 0, 1, 1, 31'h00000001));
		seg_queue.push_back(make_seg(5, 7, 4, 9, 31'h2aaaaaaa));
		seg_queue.push_back(make_seg(32'h7fff0000, 0, 32'h7fff0000, 32'h00010000,
			31'h7fffffff));
		seg_queue.push_back(make_seg(32'h12345678, 32'hedcba987, 32'h01020304,
			32'h7f000000, 31'h0));
		seg_queue.push_back(make_seg(32'hffffffff, 32'hffffffff, 0, 0, 31'h00008000));

		// Random lines, with some degenerate ones.
		for (int i = 0; i < 400; i++) begin
			x = rand_coord();
			y = rand_coord();
			if ($urandom_range(0, 24) == 0)
				seg_queue.push_back(make_seg(x, y, x, y, 31'($urandom)));
			else
				seg_queue.push_back(make_seg(x, y, rand_coord(), rand_coord(),
					$urandom_range(0, 3) == 0 ? 31'($urandom) :
					31'($urandom_range(0, 32'h000fffff))));
			// Pause the sender once midway until every result has arrived.
			if (i == 200) begin
				wait (seg_queue.size() == 0);
				drain_req = 1'b1;
				wait (quad_expect.size() == 0 && !start);
				drain_req = 1'b0;
			end
		end
		all_queued = 1'b1;

		wait (stim_done);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0 && quad_expect.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Give up after a generous fixed time.
	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
